@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication
`define ACP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

@@ hw/rtl/acp_pkg.sv @@
`default_nettype none

package acp_pkg;

    localparam int ACP_PRICE_LEVELS = 1024;
    localparam int ACP_TICK_W       = 10;
    localparam int ACP_ORD_W        = 32;
    localparam int ACP_QTY_W        = 40;
    localparam int ACP_WORD_W       = ACP_QTY_W + 1;

    typedef struct packed {
        logic accept;
        logic acc_wr;
        logic clr_wr;
        logic s_rd;
        logic s_start0;
        logic s_start_next;
        logic s_step;
        logic s_hit;
        logic s_none;
        logic d_rd;
        logic d_start_top;
        logic d_start_next;
        logic d_step;
        logic d_hit;
        logic d_none;
        logic load;
        logic s_adv;
        logic d_adv;
        logic d_take_s;
        logic emit;
        logic emit_cross;
    } t_acp_cmd;

    typedef struct packed {
        logic last;
        logic clr_last;
        logic sp_end;
        logic s_used;
        logic dp_end;
        logic d_used;
        logic no_book;
        logic s_lt_d;
        logic both_none;
        logic s_go;
        logic d_stop;
        logic d_go;
    } t_acp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/auction_clearing_price_unit.sv @@
// Channel   Direction  Transfer                        Signals
// order     in         start high while busy low       i_side i_price_tick i_quantity i_last
// result    out        one-cycle strobe o_result_valid o_clear_price o_clear_quantity o_crossed
//
// An order transaction is a read of the price level when the order is accepted, then
// the accumulate write of that level in the book of the order's side.
// An order with i_last set adds a walk over the level books, in which each book's read
// port probes one level and the following check state tests it, level by level.
// Reset and every result are followed by a clearing pass over all PRICE_LEVELS levels
// (one level per cycle); busy stays high until it ends.
// The result receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

module auction_clearing_price_unit #(
    parameter int PRICE_LEVELS = acp_pkg::ACP_PRICE_LEVELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_side,
    input  wire logic [acp_pkg::ACP_TICK_W-1:0]  i_price_tick,
    input  wire logic [acp_pkg::ACP_ORD_W-1:0]   i_quantity,
    input  wire logic                            i_last,
    output logic                                 o_result_valid,
    output logic [acp_pkg::ACP_TICK_W-1:0]       o_clear_price,
    output logic [acp_pkg::ACP_QTY_W-1:0]        o_clear_quantity,
    output logic                                 o_crossed
);
    import acp_pkg::*;

    t_acp_cmd cmd;
    t_acp_sts sts;

    acp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    acp_datapath #(
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_side           (i_side),
        .i_price_tick     (i_price_tick),
        .i_quantity       (i_quantity),
        .i_last           (i_last),
        .o_result_valid   (o_result_valid),
        .o_clear_price    (o_clear_price),
        .o_clear_quantity (o_clear_quantity),
        .o_crossed        (o_crossed)
    );

endmodule

`default_nettype wire

@@ hw/rtl/acp_ctrl.sv @@
`default_nettype none

module acp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire acp_pkg::t_acp_sts i_sts,
    output acp_pkg::t_acp_cmd      o_cmd,
    output logic                   o_busy
);
    import acp_pkg::*;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_SP    = 4'd3;
    localparam logic [3:0] ST_SC    = 4'd4;
    localparam logic [3:0] ST_DP    = 4'd5;
    localparam logic [3:0] ST_DC    = 4'd6;
    localparam logic [3:0] ST_INIT  = 4'd7;
    localparam logic [3:0] ST_TOP   = 4'd8;
    localparam logic [3:0] ST_SLOOP = 4'd9;
    localparam logic [3:0] ST_DCHK  = 4'd10;
    localparam logic [3:0] ST_DLOOP = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_SETUP = 2'd1;
    localparam logic [1:0] PH_LOOP  = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_moved, n_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_phase <= PH_FIRST;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_moved <= n_moved;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        n_moved = r_moved;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_wr = 1'b1;
                if (i_sts.last) begin
                    o_cmd.s_start0 = 1'b1;
                    n_phase        = PH_FIRST;
                    n_state        = ST_SP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SP, ST_SC: begin
                if (r_state == ST_SP && !i_sts.sp_end) begin
                    o_cmd.s_rd = 1'b1;
                    n_state    = ST_SC;
                end else if (r_state == ST_SC && !i_sts.s_used) begin
                    o_cmd.s_step = 1'b1;
                    n_state      = ST_SP;
                end else begin
                    // supply scan finished
                    o_cmd.s_hit  = (r_state == ST_SC);
                    o_cmd.s_none = (r_state == ST_SP);
                    if (r_phase == PH_LOOP) begin
                        n_state = ST_SLOOP;
                    end else begin
                        o_cmd.d_start_top  = (r_phase == PH_FIRST);
                        o_cmd.d_start_next = (r_phase != PH_FIRST);
                        n_state            = ST_DP;
                    end
                end
            end
            ST_DP, ST_DC: begin
                if (r_state == ST_DP && !i_sts.dp_end) begin
                    o_cmd.d_rd = 1'b1;
                    n_state    = ST_DC;
                end else if (r_state == ST_DC && !i_sts.d_used) begin
                    o_cmd.d_step = 1'b1;
                    n_state      = ST_DP;
                end else begin
                    // demand scan finished
                    o_cmd.d_hit  = (r_state == ST_DC);
                    o_cmd.d_none = (r_state == ST_DP);
                    if (r_phase == PH_FIRST) begin
                        n_state = ST_INIT;
                    end else if (r_phase == PH_SETUP) begin
                        n_phase = PH_LOOP;
                        n_state = ST_TOP;
                    end else begin
                        n_state = ST_DLOOP;
                    end
                end
            end
            ST_INIT: begin
                if (i_sts.no_book) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CLR;
                end else begin
                    o_cmd.load         = 1'b1;
                    o_cmd.s_start_next = 1'b1;
                    n_phase            = PH_SETUP;
                    n_state            = ST_SP;
                end
            end
            ST_TOP: begin
                if (!i_sts.s_lt_d) begin
                    n_state = ST_DONE;
                end else if (i_sts.both_none) begin
                    o_cmd.d_take_s = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_moved = 1'b0;
                    n_state = ST_SLOOP;
                end
            end
            ST_SLOOP: begin
                if (i_sts.s_go) begin
                    o_cmd.s_adv        = 1'b1;
                    o_cmd.s_start_next = 1'b1;
                    n_moved            = 1'b1;
                    n_state            = ST_SP;
                end else begin
                    n_state = ST_DCHK;
                end
            end
            ST_DCHK: begin
                if (i_sts.d_stop) begin
                    o_cmd.d_take_s = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_DLOOP;
                end
            end
            ST_DLOOP: begin
                if (i_sts.d_go) begin
                    o_cmd.d_adv        = 1'b1;
                    o_cmd.d_start_next = 1'b1;
                    n_moved            = 1'b1;
                    n_state            = ST_DP;
                end else if (!r_moved) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_TOP;
                end
            end
            ST_DONE: begin
                o_cmd.emit       = 1'b1;
                o_cmd.emit_cross = 1'b1;
                n_state          = ST_CLR;
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/acp_datapath.sv @@
`default_nettype none

module acp_datapath #(
    parameter int PRICE_LEVELS = acp_pkg::ACP_PRICE_LEVELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire acp_pkg::t_acp_cmd               i_cmd,
    output acp_pkg::t_acp_sts                    o_sts,
    input  wire logic                            i_side,
    input  wire logic [acp_pkg::ACP_TICK_W-1:0]  i_price_tick,
    input  wire logic [acp_pkg::ACP_ORD_W-1:0]   i_quantity,
    input  wire logic                            i_last,
    output logic                                 o_result_valid,
    output logic [acp_pkg::ACP_TICK_W-1:0]       o_clear_price,
    output logic [acp_pkg::ACP_QTY_W-1:0]        o_clear_quantity,
    output logic                                 o_crossed
);
    import acp_pkg::*;

    localparam int LW = $clog2(PRICE_LEVELS);

    function automatic logic [ACP_QTY_W-1:0] f_sat(input logic [ACP_QTY_W:0] x);
        f_sat = x[ACP_QTY_W] ? {ACP_QTY_W{1'b1}} : x[ACP_QTY_W-1:0];
    endfunction

    // level books: bit ACP_QTY_W is the level-present flag
    logic [ACP_WORD_W-1:0] r_sup_mem [PRICE_LEVELS];
    logic [ACP_WORD_W-1:0] r_dem_mem [PRICE_LEVELS];
    logic [ACP_WORD_W-1:0] r_srd, r_drd;

    logic                 r_side, r_last, r_tick_ok;
    logic [LW-1:0]        r_addr;
    logic [ACP_ORD_W-1:0] r_oqty;
    logic [LW-1:0]        r_clr;

    logic [LW:0]          r_sp, r_dp;
    logic [LW-1:0]        r_s, r_d;
    logic [ACP_QTY_W-1:0] r_qs, r_qd;
    logic                 r_ns_found, r_nd_found;
    logic [LW-1:0]        r_ns_idx, r_nd_idx;
    logic [ACP_QTY_W-1:0] r_ns_qty, r_nd_qty;

    logic                  r_ovalid, r_ocross;
    logic [ACP_TICK_W-1:0] r_oprice;
    logic [ACP_QTY_W-1:0]  r_ovol;

    logic                  s_we, d_we;
    logic [LW-1:0]         s_ra, d_ra, wa;
    logic [ACP_WORD_W-1:0] s_wd, d_wd;
    logic [ACP_QTY_W-1:0]  min_q;

    assign wa   = i_cmd.clr_wr ? r_clr : r_addr;
    assign s_we = i_cmd.clr_wr || (i_cmd.acc_wr && r_tick_ok && !r_side);
    assign d_we = i_cmd.clr_wr || (i_cmd.acc_wr && r_tick_ok && r_side);
    assign s_wd = i_cmd.clr_wr ? '0 :
        {1'b1, f_sat({1'b0, r_srd[ACP_QTY_W-1:0]} + (ACP_QTY_W+1)'(r_oqty))};
    assign d_wd = i_cmd.clr_wr ? '0 :
        {1'b1, f_sat({1'b0, r_drd[ACP_QTY_W-1:0]} + (ACP_QTY_W+1)'(r_oqty))};
    assign s_ra = i_cmd.s_rd ? r_sp[LW-1:0] : LW'(i_price_tick);
    assign d_ra = i_cmd.d_rd ? r_dp[LW-1:0] : LW'(i_price_tick);

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sup_mem[wa] <= s_wd;
        end
        r_srd <= r_sup_mem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dem_mem[wa] <= d_wd;
        end
        r_drd <= r_dem_mem[d_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= o_sts.clr_last ? '0 : r_clr + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_side    <= i_side;
            r_last    <= i_last;
            r_tick_ok <= (32'(i_price_tick) < 32'(PRICE_LEVELS));
            r_addr    <= LW'(i_price_tick);
            r_oqty    <= i_quantity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_start0) begin
            r_sp <= '0;
        end else if (i_cmd.s_start_next) begin
            r_sp <= {1'b0, r_ns_idx} + (LW+1)'(1);
        end else if (i_cmd.s_step) begin
            r_sp <= r_sp + (LW+1)'(1);
        end
        if (i_cmd.s_hit) begin
            r_ns_found <= 1'b1;
            r_ns_idx   <= r_sp[LW-1:0];
            r_ns_qty   <= r_srd[ACP_QTY_W-1:0];
        end else if (i_cmd.s_none) begin
            r_ns_found <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.d_start_top) begin
            r_dp <= (LW+1)'(PRICE_LEVELS - 1);
        end else if (i_cmd.d_start_next) begin
            r_dp <= {1'b0, r_nd_idx} - (LW+1)'(1);
        end else if (i_cmd.d_step) begin
            r_dp <= r_dp - (LW+1)'(1);
        end
        if (i_cmd.d_hit) begin
            r_nd_found <= 1'b1;
            r_nd_idx   <= r_dp[LW-1:0];
            r_nd_qty   <= r_drd[ACP_QTY_W-1:0];
        end else if (i_cmd.d_none) begin
            r_nd_found <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s  <= r_ns_idx;
            r_qs <= r_ns_qty;
        end else if (i_cmd.s_adv) begin
            r_s  <= r_ns_idx;
            r_qs <= f_sat({1'b0, r_qs} + {1'b0, r_ns_qty});
        end
        if (i_cmd.load) begin
            r_d  <= r_nd_idx;
            r_qd <= r_nd_qty;
        end else if (i_cmd.d_adv) begin
            r_d  <= r_nd_idx;
            r_qd <= f_sat({1'b0, r_qd} + {1'b0, r_nd_qty});
        end else if (i_cmd.d_take_s && (r_qd < r_qs)) begin
            r_d <= r_s;
        end
    end

    assign min_q = (r_qs < r_qd) ? r_qs : r_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oprice <= i_cmd.emit_cross ? ACP_TICK_W'(r_d) : '0;
            r_ovol   <= i_cmd.emit_cross ? min_q : '0;
            r_ocross <= i_cmd.emit_cross;
        end
    end

    always_comb begin
        o_sts.last      = r_last;
        o_sts.clr_last  = (r_clr == LW'(PRICE_LEVELS - 1));
        o_sts.sp_end    = (r_sp == (LW+1)'(PRICE_LEVELS));
        o_sts.s_used    = r_srd[ACP_QTY_W];
        o_sts.dp_end    = r_dp[LW];
        o_sts.d_used    = r_drd[ACP_QTY_W];
        o_sts.no_book   = !r_ns_found || !r_nd_found || (r_nd_idx < r_ns_idx);
        o_sts.s_lt_d    = (r_s < r_d);
        o_sts.both_none = !r_ns_found && !r_nd_found;
        o_sts.s_go      = (r_qs <= r_qd) && r_ns_found && (r_ns_idx <= r_d);
        o_sts.d_stop    = !r_nd_found || (r_nd_idx < r_s);
        o_sts.d_go      = (r_qd < r_qs) && r_nd_found && (r_nd_idx >= r_s);
    end

    assign o_result_valid   = r_ovalid;
    assign o_clear_price    = r_oprice;
    assign o_clear_quantity = r_ovol;
    assign o_crossed        = r_ocross;

endmodule

`default_nettype wire

@@ hw/rtl/acp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module acp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_start,
    input wire logic                           i_busy,
    input wire logic                           i_result_valid,
    input wire logic [acp_pkg::ACP_TICK_W-1:0] i_clear_price,
    input wire logic [acp_pkg::ACP_QTY_W-1:0]  i_clear_quantity,
    input wire logic                           i_crossed
);

    logic zero_result;

    assign zero_result = (i_clear_price == '0) && (i_clear_quantity == '0);

    // no two results in a row; clearing pass follows
    `ACP_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, i_result_valid, !i_result_valid)
    `ACP_ASSERT_IMP(a_busy_on_result, i_clk, i_rst_n, i_result_valid, i_busy)
    `ACP_ASSERT_IMP(a_no_trade_zero, i_clk, i_rst_n, i_result_valid && !i_crossed, zero_result)
    `ACP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_start && !i_busy, i_busy)

endmodule

bind auction_clearing_price_unit acp_checker u_acp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (start),
    .i_busy           (busy),
    .i_result_valid   (o_result_valid),
    .i_clear_price    (o_clear_price),
    .i_clear_quantity (o_clear_quantity),
    .i_crossed        (o_crossed)
);

`default_nettype wire

@@ tb/auction_clearing_price_unit_test.sv @@
`default_nettype none

module auction_clearing_price_unit_test;

    localparam int LEVELS  = acp_pkg::ACP_PRICE_LEVELS;
    localparam int TICK_W  = acp_pkg::ACP_TICK_W;
    localparam int ORD_W   = acp_pkg::ACP_ORD_W;
    localparam int QTY_W   = acp_pkg::ACP_QTY_W;

    localparam logic SIDE_ASK = 1'b0;
    localparam logic SIDE_BID = 1'b1;
    localparam logic IS_LAST  = 1'b1;
    localparam logic NOT_LAST = 1'b0;
    localparam logic CHK_TYPED = 1'b1;
    localparam logic CHK_MODEL = 1'b0;

    localparam logic [QTY_W-1:0] QTY_SAT = {QTY_W{1'b1}};
    localparam logic [ORD_W-1:0] ORD_MAX = {ORD_W{1'b1}};

    localparam int RANDOM_ITEMS = 1950;
    localparam int MAX_GAP      = 40;
    localparam int WALK_CYCLES  = 7 * LEVELS + 20;
    localparam longint CYCLE_LIMIT =
        longint'(RANDOM_ITEMS + 400) * longint'(MAX_GAP + 2 + WALK_CYCLES) * 3;

    typedef struct packed {
        logic [TICK_W-1:0] price;
        logic [QTY_W-1:0]  volume;
        logic              crossed;
    } t_fill;

    typedef struct packed {
        logic              side;
        logic [TICK_W-1:0] tick;
        logic [ORD_W-1:0]  qty;
        logic              last;
        logic              typed;
        t_fill             fill;
    } t_order_row;

    localparam t_fill NO_TRADE = '{price: '0, volume: '0, crossed: 1'b0};

    localparam int SCRIPT_LEN = 24;

    t_order_row script [SCRIPT_LEN] = '{
        '{SIDE_ASK, 10'd5,    32'd10,  IS_LAST,  CHK_TYPED, NO_TRADE},
        '{SIDE_BID, 10'd1023, ORD_MAX, IS_LAST,  CHK_TYPED, NO_TRADE},
        '{SIDE_ASK, 10'd600,  32'd7,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd500,  32'd9,   IS_LAST,  CHK_TYPED, NO_TRADE},
        '{SIDE_ASK, 10'd0,    ORD_MAX, NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd1023, ORD_MAX, IS_LAST,  CHK_TYPED,
          '{10'd1023, {8'd0, ORD_MAX}, 1'b1}},
        '{SIDE_ASK, 10'd300,  32'd4,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd300,  32'd6,   IS_LAST,  CHK_TYPED, '{10'd300, 40'd4, 1'b1}},
        '{SIDE_ASK, 10'd100,  32'd0,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd200,  32'd0,   IS_LAST,  CHK_TYPED, '{10'd200, 40'd0, 1'b1}},
        '{SIDE_ASK, 10'd10,   32'd5,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd20,   32'd5,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd30,   32'd5,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd40,   32'd3,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd25,   32'd4,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd15,   32'd8,   IS_LAST,  CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd10,   32'd5,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd20,   32'd5,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd50,   32'd3,   IS_LAST,  CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd10,   32'd2,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd10,   32'd3,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_ASK, 10'd50,   32'd1,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd40,   32'd9,   NOT_LAST, CHK_MODEL, NO_TRADE},
        '{SIDE_BID, 10'd20,   32'd1,   IS_LAST,  CHK_MODEL, NO_TRADE}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              i_side = 1'b0;
    logic [TICK_W-1:0] i_price_tick = '0;
    logic [ORD_W-1:0]  i_quantity = '0;
    logic              i_last = 1'b0;
    logic              busy;
    logic              o_result_valid;
    logic [TICK_W-1:0] o_clear_price;
    logic [QTY_W-1:0]  o_clear_quantity;
    logic              o_crossed;

    logic [QTY_W-1:0] ask_book [LEVELS];
    bit               ask_present [LEVELS];
    logic [QTY_W-1:0] bid_book [LEVELS];
    bit               bid_present [LEVELS];

    t_fill  pending_fills [$];
    int     err_count = 0;
    longint cycle_count = 0;

    auction_clearing_price_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_side           (i_side),
        .i_price_tick     (i_price_tick),
        .i_quantity       (i_quantity),
        .i_last           (i_last),
        .o_result_valid   (o_result_valid),
        .o_clear_price    (o_clear_price),
        .o_clear_quantity (o_clear_quantity),
        .o_crossed        (o_crossed)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [QTY_W-1:0] qty_add_sat(logic [QTY_W-1:0] a, logic [QTY_W-1:0] b);
        logic [QTY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QTY_W] ? QTY_SAT : s[QTY_W-1:0];
    endfunction

    function automatic void wipe_books();
        for (int i = 0; i < LEVELS; i++) begin
            ask_book[i]    = '0;
            ask_present[i] = 1'b0;
            bid_book[i]    = '0;
            bid_present[i] = 1'b0;
        end
    endfunction

    function automatic int next_ask(int from);
        for (int i = from + 1; i < LEVELS; i++)
            if (ask_present[i]) return i;
        return -1;
    endfunction

    function automatic int next_bid(int from);
        for (int i = from - 1; i >= 0; i--)
            if (bid_present[i]) return i;
        return -1;
    endfunction

    // ask side climbs from the lowest level, bid side descends from the highest
    function automatic t_fill find_crossing();
        t_fill            f;
        int               s, d, ns, nd, ps, pd;
        logic [QTY_W-1:0] qs, qd;
        bit               moved, done;
        f = NO_TRADE;
        s = next_ask(-1);
        d = next_bid(LEVELS);
        if (s >= 0 && d >= 0 && d >= s) begin
            ps = s;
            pd = d;
            qs = ask_book[s];
            qd = bid_book[d];
            done = 1'b0;
            while (!done && ps < pd) begin
                moved = 1'b0;
                ns = next_ask(s);
                nd = next_bid(d);
                if (ns < 0 && nd < 0) begin
                    if (qd < qs) pd = ps;
                    done = 1'b1;
                end else begin
                    while (qs <= qd && ns >= 0 && ns <= pd) begin
                        s = ns;
                        ps = s;
                        qs = qty_add_sat(qs, ask_book[s]);
                        ns = next_ask(s);
                        moved = 1'b1;
                    end
                    if (nd < 0 || nd < ps) begin
                        if (qd < qs) pd = ps;
                        done = 1'b1;
                    end else begin
                        while (qd < qs && nd >= 0 && nd >= ps) begin
                            d = nd;
                            pd = d;
                            qd = qty_add_sat(qd, bid_book[d]);
                            nd = next_bid(d);
                            moved = 1'b1;
                        end
                        if (!moved) done = 1'b1;
                    end
                end
            end
            f.price   = pd[TICK_W-1:0];
            f.volume  = (qs < qd) ? qs : qd;
            f.crossed = 1'b1;
        end
        return f;
    endfunction

    function automatic bit book_order(logic side, logic [TICK_W-1:0] tick,
                                      logic [ORD_W-1:0] qty, logic last, output t_fill f);
        f = NO_TRADE;
        if (side == SIDE_BID) begin
            bid_book[tick]    = qty_add_sat(bid_book[tick], {{(QTY_W-ORD_W){1'b0}}, qty});
            bid_present[tick] = 1'b1;
        end else begin
            ask_book[tick]    = qty_add_sat(ask_book[tick], {{(QTY_W-ORD_W){1'b0}}, qty});
            ask_present[tick] = 1'b1;
        end
        if (!last) return 1'b0;
        f = find_crossing();
        wipe_books();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, MAX_GAP);
    endfunction

    function automatic int clamp_tick(int v);
        if (v < 0) return 0;
        if (v > LEVELS - 1) return LEVELS - 1;
        return v;
    endfunction

    function automatic logic [ORD_W-1:0] pick_qty(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 15);
            2: return $urandom_range(0, 5000);
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return ORD_MAX - $urandom_range(0, 3);
                    default: return $urandom_range(1, 100);
                endcase
            end
        endcase
    endfunction

    task automatic send_order(logic side, logic [TICK_W-1:0] tick, logic [ORD_W-1:0] qty,
                              logic last, logic typed, t_fill typed_fill);
        int    gap;
        t_fill f;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_side       <= side;
        i_price_tick <= tick;
        i_quantity   <= qty;
        i_last       <= last;
        do @(posedge i_clk); while (busy);
        // transaction taken at this edge
        if (book_order(side, tick, qty, last, f))
            pending_fills.push_back(typed ? typed_fill : f);
    endtask

    task automatic drain_fills();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_fills.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_fill want;
        if (i_rst_n && o_result_valid) begin
            if (pending_fills.size() == 0) begin
                $display("%0t: unexpected result price=%0d qty=%0d crossed=%0b",
                         $time, o_clear_price, o_clear_quantity, o_crossed);
                err_count++;
            end else begin
                want = pending_fills.pop_front();
                if (o_clear_price !== want.price) begin
                    $display("%0t: clear_price expected %0d actual %0d",
                             $time, want.price, o_clear_price);
                    err_count++;
                end
                if (o_clear_quantity !== want.volume) begin
                    $display("%0t: clear_quantity expected %0d actual %0d",
                             $time, want.volume, o_clear_quantity);
                    err_count++;
                end
                if (o_crossed !== want.crossed) begin
                    $display("%0t: crossed expected %0b actual %0b",
                             $time, want.crossed, o_crossed);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("auction_clearing_price_unit_test: errors");
            $finish;
        end
    end

    initial begin
        int   sent, auctions, n, kind, center, spread, bias, qmode, t;
        logic sd;
        sent = 0;
        auctions = 0;
        wipe_books();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++)
            send_order(script[r].side, script[r].tick, script[r].qty, script[r].last,
                       script[r].typed, script[r].fill);
        drain_fills();

        while (sent < RANDOM_ITEMS) begin
            if (auctions % 16 == 15) drain_fills();
            kind   = $urandom_range(0, 99);
            n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            center = $urandom_range(0, LEVELS - 1);
            case ($urandom_range(0, 3))
                0: spread = 2;
                1: spread = 8;
                2: spread = 40;
                default: spread = 300;
            endcase
            bias  = int'($urandom_range(0, spread)) - spread / 3;
            qmode = $urandom_range(0, 3);
            // heavy books: many near-full orders on up to four adjacent levels
            if (auctions == 30 || auctions == 110) begin
                n = 300;
                kind = 200;
            end
            for (int k = 0; k < n; k++) begin
                sd = $urandom_range(0, 1);
                if (kind == 200) begin
                    t = clamp_tick(center + int'($urandom_range(0, 3)));
                    send_order(sd, t[TICK_W-1:0], ORD_MAX - $urandom_range(0, 15),
                               (k == n - 1), CHK_MODEL, NO_TRADE);
                end else begin
                    if (kind < 8)
                        t = $urandom_range(0, LEVELS - 1);
                    else if (kind < 18)
                        case ($urandom_range(0, 3))
                            0: t = 0;
                            1: t = 1;
                            2: t = LEVELS - 2;
                            default: t = LEVELS - 1;
                        endcase
                    else if (sd == SIDE_ASK)
                        t = clamp_tick(center - bias + int'($urandom_range(0, 2 * spread))
                                       - spread);
                    else
                        t = clamp_tick(center + bias + int'($urandom_range(0, 2 * spread))
                                       - spread);
                    send_order(sd, t[TICK_W-1:0], pick_qty(kind < 8 ? 0 : qmode),
                               (k == n - 1), CHK_MODEL, NO_TRADE);
                end
            end
            sent += n;
            auctions++;
        end

        start <= 1'b0;
        while (pending_fills.size() != 0) @(posedge i_clk);
        repeat (WALK_CYCLES + 2 * LEVELS) @(posedge i_clk);
        if (err_count == 0 && pending_fills.size() == 0)
            $display("auction_clearing_price_unit_test: clean");
        else
            $display("auction_clearing_price_unit_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
